>>> rtl/core/ctp_pkg.sv
// Shared types, constants and helpers for the capacitive touch qualifier.
package ctp_pkg;

   // Number of pads held in the per-pad state.
   localparam int PAD_COUNT = 30;
   localparam int PAD_IDX_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

   // Field widths fixed by the interface.
   localparam int MODE_W   = 3;
   localparam int PAD_W    = 5;
   localparam int COUNT_W  = 16;
   localparam int THR_W    = 17;
   localparam int MASK_W   = 30;
   localparam int SAMPLE_W = 4;
   localparam int PCT_W    = 7;
   localparam int PROD_W   = THR_W + PCT_W;
   localparam int QUOT_W   = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = MASK_W;

   localparam logic [THR_W-1:0] THR_MAX = '1;

   // Reciprocal of one hundred scaled by two to the 31st, rounded up. Exact for
   // every dividend below two to the 24th.
   localparam int RECIP_W     = 25;
   localparam int RECIP_SHIFT = 31;
   localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;

   // Operating modes.
   localparam logic [MODE_W-1:0] MODE_SCAN        = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CAL_START   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CAL_SAMPLE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FIXED_LOAD  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STORED_LOAD = 3'd4;
   localparam logic [MODE_W-1:0] MODE_READ        = 3'd5;

   // Register indexes on the control port.
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_ENABLE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS   = 3'd4;

   typedef enum logic [1:0] {
      THR_CAL    = 2'd0,
      THR_FIXED  = 2'd1,
      THR_STORED = 2'd2
   } thr_kind_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [PAD_W-1:0]   pad;
      logic [COUNT_W-1:0] remaining;
      logic [THR_W-1:0]   threshold_a;
      logic [THR_W-1:0]   threshold_b;
   } ctp_req_type;

   typedef struct packed {
      logic [PAD_W-1:0]   pad_out;
      logic [COUNT_W-1:0] reading;
      logic               is_touched;
      logic               is_active;
      logic               cal_done;
      logic               pad_enabled;
   } ctp_rsp_type;

   typedef struct packed {
      logic [MASK_W-1:0]   pad_enable_mask;
      logic [COUNT_W-1:0]  timeout_count;
      logic [SAMPLE_W-1:0] cal_sample_count;
      logic [PCT_W-1:0]    margin_pct;
      logic [PCT_W-1:0]    hysteresis_pct;
   } ctp_cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [PAD_IDX_W-1:0] pad;
      thr_kind_type         kind;
      logic [THR_W-1:0]     base;
      logic [THR_W-1:0]     alt;
      logic [PROD_W-1:0]    prod_margin;
      logic [PROD_W-1:0]    prod_hyst;
   } ctp_thr_req_type;

   // Floor of a product over one hundred, by multiplication with the reciprocal.
   function automatic logic [QUOT_W-1:0] div100(input logic [PROD_W-1:0] x);
      logic [PROD_W+RECIP_W-1:0] p;
      p = {{RECIP_W{1'b0}}, x} * {{PROD_W{1'b0}}, RECIP_100};
      return p[RECIP_SHIFT +: QUOT_W];
   endfunction

endpackage

>>> rtl/core/ctp_thr_store.sv
// Threshold write-back stage and per-pad on and off threshold storage.
module ctp_thr_store (
   input  logic                             clock,
   input  logic                             reset,
   input  ctp_pkg::ctp_thr_req_type         wr_req,
   input  logic [ctp_pkg::PAD_IDX_W-1:0]    rd_idx,
   output logic [ctp_pkg::THR_W-1:0]        rd_on,
   output logic [ctp_pkg::THR_W-1:0]        rd_off
);
   import ctp_pkg::*;

   logic            wb_valid_ff;
   ctp_thr_req_type wb_ff;
   logic [THR_W-1:0] on_ff  [PAD_COUNT];
   logic [THR_W-1:0] off_ff [PAD_COUNT];

   logic [QUOT_W-1:0]  q_margin;
   logic [QUOT_W-1:0]  q_hyst;
   logic [QUOT_W:0]    sum_on;
   logic [QUOT_W:0]    sum_off;
   logic [THR_W-1:0]   new_on;
   logic [THR_W-1:0]   new_off;

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else begin
         wb_valid_ff <= wr_req.valid;
      end
   end

   always_ff @(posedge clock) begin
      wb_ff <= wr_req;
   end

   always_comb begin
      q_margin = div100(wb_ff.prod_margin);
      q_hyst   = div100(wb_ff.prod_hyst);
      sum_on   = (QUOT_W+1)'(wb_ff.base) + (QUOT_W+1)'(q_margin);
      sum_off  = (QUOT_W+1)'(wb_ff.base) + (QUOT_W+1)'(q_hyst);
      case (wb_ff.kind)
         THR_CAL: begin
            new_on  = (sum_on  > (QUOT_W+1)'(THR_MAX)) ? THR_MAX : sum_on[THR_W-1:0];
            new_off = (sum_off > (QUOT_W+1)'(THR_MAX)) ? THR_MAX : sum_off[THR_W-1:0];
         end
         THR_FIXED: begin
            new_on = wb_ff.base;
            if (q_hyst > QUOT_W'(wb_ff.base)) begin
               new_off = '0;
            end else begin
               new_off = wb_ff.base - q_hyst[THR_W-1:0];
            end
         end
         default: begin
            new_on  = wb_ff.base;
            new_off = wb_ff.alt;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wb_valid_ff) begin
         on_ff[wb_ff.pad]  <= new_on;
         off_ff[wb_ff.pad] <= new_off;
      end
   end

   // A write still in flight for the same pad takes precedence over storage.
   always_comb begin
      if (wb_valid_ff && (wb_ff.pad == rd_idx)) begin
         rd_on  = new_on;
         rd_off = new_off;
      end else begin
         rd_on  = on_ff[rd_idx];
         rd_off = off_ff[rd_idx];
      end
   end

endmodule

>>> rtl/core/ctp_pad_update.sv
// Per-pad flags, calibration state and the decision logic for one item.
module ctp_pad_update (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  ctp_pkg::ctp_req_type             item,
   input  ctp_pkg::ctp_cfg_type             cfg,
   input  logic [ctp_pkg::THR_W-1:0]        cur_on,
   input  logic [ctp_pkg::THR_W-1:0]        cur_off,
   output logic [ctp_pkg::PAD_IDX_W-1:0]    pad_idx,
   output ctp_pkg::ctp_rsp_type             result,
   output ctp_pkg::ctp_thr_req_type         thr_req
);
   import ctp_pkg::*;

   logic                running_ff  [PAD_COUNT];
   logic                active_ff   [PAD_COUNT];
   logic                touched_ff  [PAD_COUNT];
   logic [COUNT_W-1:0]  baseline_ff [PAD_COUNT];
   logic [SAMPLE_W-1:0] taken_ff    [PAD_COUNT];

   logic                running_in;
   logic                active_in;
   logic                touched_in;
   logic [COUNT_W-1:0]  baseline_in;
   logic [SAMPLE_W-1:0] taken_in;

   logic                cur_running;
   logic                cur_active;
   logic                cur_touched;
   logic [COUNT_W-1:0]  cur_baseline;
   logic [SAMPLE_W-1:0] cur_taken;

   logic [31:0]         mask_ext;
   logic                enabled;
   logic [COUNT_W-1:0]  meas;
   logic                sat;
   logic [COUNT_W-1:0]  rd;
   logic                done;
   logic                do_start;
   logic                thr_we;
   thr_kind_type        thr_kind;
   logic [THR_W-1:0]    opnd;

   assign pad_idx  = item.pad[PAD_IDX_W-1:0];
   assign mask_ext = 32'(cfg.pad_enable_mask);
   assign enabled  = ({1'b0, item.pad} < (PAD_W+1)'(PAD_COUNT)) && mask_ext[item.pad];

   assign cur_running  = running_ff[pad_idx];
   assign cur_active   = active_ff[pad_idx];
   assign cur_touched  = touched_ff[pad_idx];
   assign cur_baseline = baseline_ff[pad_idx];
   assign cur_taken    = taken_ff[pad_idx];

   always_comb begin
      if (item.remaining == '0) begin
         meas = cfg.timeout_count;
      end else if (item.remaining > cfg.timeout_count) begin
         meas = '0;
      end else begin
         meas = cfg.timeout_count - item.remaining;
      end
      sat = (meas >= cfg.timeout_count);

      running_in  = cur_running;
      active_in   = cur_active;
      touched_in  = cur_touched;
      baseline_in = cur_baseline;
      taken_in    = cur_taken;
      rd          = '0;
      done        = 1'b0;
      do_start    = 1'b0;
      thr_we      = 1'b0;
      thr_kind    = THR_CAL;

      case (item.mode)
         MODE_SCAN: begin
            if (cur_active) begin
               rd = meas;
               if (!sat) begin
                  if (!cur_touched && (THR_W'(meas) > cur_on)) begin
                     touched_in = 1'b1;
                  end else if (cur_touched && (THR_W'(meas) < cur_off)) begin
                     touched_in = 1'b0;
                  end
               end
            end
         end
         MODE_CAL_START: begin
            do_start = 1'b1;
         end
         MODE_CAL_SAMPLE: begin
            if (cur_running) begin
               rd = meas;
               if (sat) begin
                  active_in  = 1'b0;
                  running_in = 1'b0;
                  done       = 1'b1;
               end else begin
                  baseline_in = (meas < cur_baseline) ? meas : cur_baseline;
                  taken_in    = cur_taken + SAMPLE_W'(1);
                  if (taken_in >= cfg.cal_sample_count) begin
                     thr_we     = 1'b1;
                     thr_kind   = THR_CAL;
                     active_in  = 1'b1;
                     touched_in = 1'b0;
                     running_in = 1'b0;
                     done       = 1'b1;
                  end
               end
            end
         end
         MODE_FIXED_LOAD, MODE_STORED_LOAD: begin
            if (item.threshold_a == '0) begin
               do_start = 1'b1;
            end else begin
               thr_we     = 1'b1;
               thr_kind   = (item.mode == MODE_FIXED_LOAD) ? THR_FIXED : THR_STORED;
               active_in  = 1'b1;
               touched_in = 1'b0;
               running_in = 1'b0;
            end
         end
         MODE_READ: begin
            if (cur_active) begin
               rd = meas;
            end
         end
         default: begin
            rd = '0;
         end
      endcase

      if (do_start) begin
         baseline_in = '1;
         taken_in    = '0;
         if (cfg.cal_sample_count == '0) begin
            running_in = 1'b0;
            active_in  = 1'b0;
            done       = 1'b1;
         end else begin
            running_in = 1'b1;
         end
      end

      // Calibration works from the baseline; both kinds of load take the on level as given.
      opnd = (thr_kind == THR_CAL) ? THR_W'(baseline_in) : item.threshold_a;
   end

   always_comb begin
      thr_req.valid       = step && enabled && thr_we;
      thr_req.pad         = pad_idx;
      thr_req.kind        = thr_kind;
      thr_req.base        = opnd;
      thr_req.alt         = item.threshold_b;
      thr_req.prod_margin = PROD_W'(opnd) * PROD_W'(cfg.margin_pct);
      thr_req.prod_hyst   = PROD_W'(opnd) * PROD_W'(cfg.hysteresis_pct);
   end

   always_comb begin
      result.pad_out = item.pad;
      if (enabled) begin
         result.reading     = rd;
         result.is_touched  = touched_in;
         result.is_active   = active_in;
         result.cal_done    = done;
         result.pad_enabled = 1'b1;
      end else begin
         result.reading     = '0;
         result.is_touched  = 1'b0;
         result.is_active   = 1'b0;
         result.cal_done    = 1'b0;
         result.pad_enabled = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAD_COUNT; i++) begin
            running_ff[i] <= 1'b0;
            active_ff[i]  <= 1'b0;
            touched_ff[i] <= 1'b0;
         end
      end else if (step && enabled) begin
         running_ff[pad_idx] <= running_in;
         active_ff[pad_idx]  <= active_in;
         touched_ff[pad_idx] <= touched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && enabled) begin
         baseline_ff[pad_idx] <= baseline_in;
         taken_ff[pad_idx]    <= taken_in;
      end
   end

endmodule

>>> rtl/core/cap_touch_calibrate_hysteresis.sv
// Top level of the capacitive touch qualifier: control registers, beat staging, result register.
// An accepted request beat waits in the input stage and moves into the result register when that is free.
// Throughput: one beat per cycle while rsp_ready holds; the per-pad decision for each item is combinational.
// A threshold write-back register follows the per-pad update and is forwarded to later items of that pad.
// Reset (synchronous) empties both stages, restores register defaults and clears pad flags.
// There is no clearing pass; the block takes beats from the first cycle after reset.
module cap_touch_calibrate_hysteresis (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ctp_pkg::ctp_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ctp_pkg::ctp_rsp_type               rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ctp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ctp_pkg::CSR_DATA_W-1:0]     csr_data
);
   import ctp_pkg::*;

   // Control registers. Writes must arrive only while the block is idle; the block
   // itself does not enforce this. The port is always ready.
   ctp_cfg_type cfg_ff;
   ctp_cfg_type cfg_in;

   // Input stage: holds one accepted beat until the result register can take it.
   logic        in_valid_ff;
   logic        in_valid_in;
   ctp_req_type in_data_ff;
   ctp_req_type in_data_in;

   // Result register: a finished beat waits here while the next one is staged.
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   ctp_rsp_type rsp_data_ff;
   ctp_rsp_type rsp_data_in;

   logic                  advance;
   logic [PAD_IDX_W-1:0]  pad_idx;
   logic [THR_W-1:0]      cur_on;
   logic [THR_W-1:0]      cur_off;
   ctp_rsp_type           result;
   ctp_thr_req_type       thr_req;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PAD_ENABLE:   cfg_in.pad_enable_mask  = csr_data[MASK_W-1:0];
            CSR_TIMEOUT:      cfg_in.timeout_count    = csr_data[COUNT_W-1:0];
            CSR_SAMPLE_COUNT: cfg_in.cal_sample_count = csr_data[SAMPLE_W-1:0];
            CSR_MARGIN:       cfg_in.margin_pct       = csr_data[PCT_W-1:0];
            CSR_HYSTERESIS:   cfg_in.hysteresis_pct   = csr_data[PCT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pad_enable_mask  <= '0;
         cfg_ff.timeout_count    <= 16'd10000;
         cfg_ff.cal_sample_count <= 4'd8;
         cfg_ff.margin_pct       <= 7'd15;
         cfg_ff.hysteresis_pct   <= 7'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The staged beat moves on when the result register is empty or is being
   // emptied in this cycle; the per-pad state commits at the same edge.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Flags, baseline and sample count per pad, and the decision for the
   // staged beat. Threshold products leave here for the write-back stage.
   ctp_pad_update u_pad_update (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (in_data_ff),
      .cfg     (cfg_ff),
      .cur_on  (cur_on),
      .cur_off (cur_off),
      .pad_idx (pad_idx),
      .result  (result),
      .thr_req (thr_req)
   );

   // Division by one hundred and saturation of the new thresholds happen after the
   // write-back register; a scan of the same pad meanwhile sees the new values.
   ctp_thr_store u_thr_store (
      .clock  (clock),
      .reset  (reset),
      .wr_req (thr_req),
      .rd_idx (pad_idx),
      .rd_on  (cur_on),
      .rd_off (cur_off)
   );

endmodule
